// ----- rtl/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mcs_pkg
// shared types and constants of the macd crossover signal block
// ----------------------------------------------------------------------------
package mcs_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int ALPHA_W    = FRAC_BITS + 1;
    localparam int ALPHA_NUM  = 2 << FRAC_BITS;
    localparam int PRICE_W    = 32;
    localparam int VAL_W      = 48;
    localparam int EMA_W      = VAL_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL = 2'd2;

    typedef logic [1:0] trade_t;
    localparam trade_t TRADE_NONE = 2'd0;
    localparam trade_t TRADE_BUY  = 2'd1;
    localparam trade_t TRADE_SELL = 2'd2;

    // one request to the shared average update unit
    typedef struct packed {
        logic                      start;
        logic signed [EMA_W-1:0]   x;
        logic signed [EMA_W-1:0]   ema;
        logic [ALPHA_W-1:0]        alpha;
    } ema_req_t;

endpackage

// ----- rtl/mcs_ram.sv -----
// ----------------------------------------------------------------------------
// mcs_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module mcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/mcs_ema_unit.sv -----
// ----------------------------------------------------------------------------
// mcs_ema_unit
// three stage update ema + round((x - ema) * alpha / 2^frac)
// ----------------------------------------------------------------------------
module mcs_ema_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mcs_pkg::ema_req_t                   req,
    output logic                                done,
    output logic signed [mcs_pkg::EMA_W-1:0]    result
);
    import mcs_pkg::*;

    localparam int PW = EMA_W + 1 + ALPHA_W;

    logic              v1_reg, v2_reg, v3_reg;
    logic [EMA_W:0]    mag1_reg;
    logic              neg1_reg, neg2_reg;
    logic signed [EMA_W-1:0] ema1_reg, ema2_reg;
    logic [ALPHA_W-1:0] alpha1_reg;
    logic [PW-1:0]     prod2_reg;
    logic signed [EMA_W-1:0] res_reg;

    logic signed [EMA_W:0]   diff;
    logic [PW-1:0]           rnd;
    logic signed [EMA_W+1:0] adj;
    logic signed [EMA_W+1:0] sum;

    always_comb
    begin
        diff = {req.x[EMA_W-1], req.x} - {req.ema[EMA_W-1], req.ema};
        rnd  = (prod2_reg + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        adj  = neg2_reg ? -$signed({1'b0, rnd[EMA_W:0]}) : $signed({1'b0, rnd[EMA_W:0]});
        sum  = {{2{ema2_reg[EMA_W-1]}}, ema2_reg} + adj;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req.start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // magnitude and sign of the difference
        mag1_reg   <= diff[EMA_W] ? (EMA_W + 1)'(-diff) : (EMA_W + 1)'(diff);
        neg1_reg   <= diff[EMA_W];
        ema1_reg   <= req.ema;
        alpha1_reg <= req.alpha;
        // scale by alpha
        prod2_reg  <= PW'(mag1_reg) * PW'(alpha1_reg);
        neg2_reg   <= neg1_reg;
        ema2_reg   <= ema1_reg;
        // round half away from zero and accumulate
        res_reg    <= sum[EMA_W-1:0];
    end

    assign done   = v3_reg;
    assign result = res_reg;

endmodule

// ----- rtl/macd_crossover_signal.sv -----
// ----------------------------------------------------------------------------
// macd_crossover_signal
// macd signal line crossover detector, fixed point with 16 fraction bits
// ----------------------------------------------------------------------------
// One item is one closing price; every item gives one result. Prices sit in a
// ram of MAX_SLOW*WINDOW_FACTOR entries and macd values in a ram of MAX_SIGNAL
// entries. Per item the sequencer walks the kept price window once (win
// entries) and updates the fast and the slow average through one shared
// three stage update unit, then walks sig entries of the macd ram for the
// signal line (win = min(WINDOW_FACTOR*slow, prices seen), sig = signal
// period). The signal walk is left out while fewer than sig macd values
// exist, and items before slow prices skip both walks. The next item is
// taken only once the sequencer is back in idle. A result that is not
// taken holds the sequencer in its last state for as long as it waits. A
// finished result waits in the output register while the next item is
// taken. Configuration writes go through cfg_we / cfg_index / cfg_data and
// are meant only while the block is idle.
module macd_crossover_signal #(
    parameter int MAX_SLOW      = 64,
    parameter int WINDOW_FACTOR = 3,
    parameter int MAX_SIGNAL    = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [mcs_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mcs_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [mcs_pkg::PRICE_W-1:0]            close_price,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output mcs_pkg::trade_t                        trade_signal,
    output logic signed [mcs_pkg::VAL_W-1:0]       macd_value,
    output logic signed [mcs_pkg::VAL_W-1:0]       signal_value,
    output logic                                   ready_res,
    output logic                                   config_error
);
    import mcs_pkg::*;

    localparam int PRICE_DEPTH = MAX_SLOW * WINDOW_FACTOR;
    localparam int PA_W    = $clog2(PRICE_DEPTH);
    localparam int CNT_W   = $clog2(PRICE_DEPTH + 1);
    localparam int SLW     = $clog2(MAX_SLOW + 1);
    localparam int SGW     = $clog2(MAX_SIGNAL + 1);
    localparam int MA_W    = MAX_SIGNAL > 1 ? $clog2(MAX_SIGNAL) : 1;
    localparam int TAB_MAX = MAX_SLOW > 63 ? MAX_SLOW : 63;
    localparam int TIDX_W  = $clog2(TAB_MAX + 1);
    localparam int MC_W    = 6;
    localparam logic [MC_W-1:0] MCOUNT_CAP = '1;
    localparam logic signed [EMA_W-1:0] S48_MAX = EMA_W'({1'b0, {(VAL_W-1){1'b1}}});
    localparam logic signed [EMA_W-1:0] S48_MIN = -S48_MAX - EMA_W'(1);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_SETUP = 12'b000000000010,
        ST_P_RD  = 12'b000000000100,
        ST_P_X   = 12'b000000001000,
        ST_P_WF  = 12'b000000010000,
        ST_P_WS  = 12'b000000100000,
        ST_M_CALC= 12'b000001000000,
        ST_G_RD  = 12'b000010000000,
        ST_G_X   = 12'b000100000000,
        ST_G_W   = 12'b001000000000,
        ST_G_END = 12'b010000000000,
        ST_FIN   = 12'b100000000000
    } state_t;

    // alpha = round(2^(frac+1) / (p+1)) for every period
    logic [ALPHA_W-1:0] alpha_tab [TAB_MAX+1];
    for (genvar g = 0; g <= TAB_MAX; g++)
    begin : g_alpha
        localparam int Den   = g + 1;
        localparam int Alpha = (ALPHA_NUM + Den / 2) / Den;
        assign alpha_tab[g] = ALPHA_W'(Alpha);
    end

    state_t state_reg, state_next;

    // configuration
    logic [5:0] fast_len_reg, signal_len_reg;
    logic [6:0] slow_len_reg;

    // per item settings, latched when the item is taken
    logic [ALPHA_W-1:0] alpha_f_reg, alpha_s_reg, alpha_g_reg;
    logic [SLW-1:0]     slow_e_reg;
    logic [SGW-1:0]     sig_e_reg;
    logic               err_reg;
    logic               ready_hit_reg;

    // history state
    logic [PA_W-1:0]  head_reg, idx_reg;
    logic [CNT_W-1:0] count_reg, left_reg;
    logic [MA_W-1:0]  mhead_reg, midx_reg;
    logic [MC_W-1:0]  mcount_reg;
    logic [1:0]       scount_reg;
    logic             ready_flag_reg, first_reg;
    logic signed [VAL_W-1:0] prior_reg, cur_reg, pair0_reg, pair1_reg;
    logic signed [EMA_W-1:0] x_reg, ema_f_reg, ema_s_reg, ema_g_reg;

    // output register
    logic               out_valid_reg, ready_out_reg, err_out_reg;
    trade_t             trade_reg;
    logic signed [VAL_W-1:0] macd_out_reg, sig_out_reg;

    // effective periods from the current registers
    logic [5:0]         fast_e;
    logic [SLW-1:0]     slow_c;
    logic [SGW-1:0]     sig_c;
    logic               err_c;

    always_comb
    begin
        fast_e = (fast_len_reg == 6'd0) ? 6'd1 : fast_len_reg;
        if (slow_len_reg == 7'd0)
            slow_c = SLW'(1);
        else if (32'(slow_len_reg) > 32'(MAX_SLOW))
            slow_c = SLW'(MAX_SLOW);
        else
            slow_c = SLW'(slow_len_reg);
        if (signal_len_reg == 6'd0)
            sig_c = SGW'(1);
        else if (32'(signal_len_reg) > 32'(MAX_SIGNAL))
            sig_c = SGW'(MAX_SIGNAL);
        else
            sig_c = SGW'(signal_len_reg);
        err_c = (fast_len_reg == 6'd0) || ({1'b0, fast_len_reg} >= slow_len_reg);
    end

    // rams
    logic                p_we, p_re, m_we, m_re;
    logic [PRICE_W-1:0]  p_rdata;
    logic [VAL_W-1:0]    m_rdata;
    logic signed [VAL_W-1:0] macd_new;

    assign in_ready = (state_reg == ST_IDLE);
    assign p_we     = in_valid && in_ready;
    assign p_re     = (state_reg == ST_P_RD);
    assign m_we     = (state_reg == ST_M_CALC);
    assign m_re     = (state_reg == ST_G_RD);

    mcs_ram #(.WIDTH(PRICE_W), .DEPTH(PRICE_DEPTH)) u_price_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (head_reg),
        .wdata (close_price),
        .re    (p_re),
        .raddr (idx_reg),
        .rdata (p_rdata)
    );

    mcs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SIGNAL)) u_macd_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (mhead_reg),
        .wdata (macd_new),
        .re    (m_re),
        .raddr (midx_reg),
        .rdata (m_rdata)
    );

    // shared average update unit
    ema_req_t                req;
    logic                    ema_done;
    logic signed [EMA_W-1:0] ema_res;
    logic signed [EMA_W-1:0] x_price, x_macd;

    assign x_price = EMA_W'({2'b00, p_rdata, {FRAC_BITS{1'b0}}});
    assign x_macd  = {{(EMA_W-VAL_W){m_rdata[VAL_W-1]}}, m_rdata};

    always_comb
    begin
        req = '0;
        unique case (state_reg)
            ST_P_X:
            begin
                req.start = !first_reg;
                req.x     = x_price;
                req.ema   = ema_f_reg;
                req.alpha = alpha_f_reg;
            end
            ST_P_WF:
            begin
                req.start = ema_done;
                req.x     = x_reg;
                req.ema   = ema_s_reg;
                req.alpha = alpha_s_reg;
            end
            ST_G_X:
            begin
                req.start = !first_reg;
                req.x     = x_macd;
                req.ema   = ema_g_reg;
                req.alpha = alpha_g_reg;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    mcs_ema_unit u_ema (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .done   (ema_done),
        .result (ema_res)
    );

    // window setup
    logic [CNT_W-1:0] win_full, win;
    logic [CNT_W:0]   p_start;
    logic             win_go, win_ready;

    always_comb
    begin
        win_full  = CNT_W'(slow_e_reg) * CNT_W'(WINDOW_FACTOR);
        win       = (win_full > count_reg) ? count_reg : win_full;
        p_start   = {1'b0, CNT_W'(head_reg)}
                  + ((CNT_W'(head_reg) < win) ? (CNT_W + 1)'(PRICE_DEPTH) : '0)
                  - {1'b0, win};
        win_go    = win >= CNT_W'(slow_e_reg);
        win_ready = {1'b0, win} >= ((CNT_W + 1)'(slow_e_reg) + (CNT_W + 1)'(sig_e_reg));
    end

    // macd update
    logic signed [EMA_W-1:0] macd_diff;
    logic [MA_W-1:0]         mhead_new;
    logic [MC_W-1:0]         mcount_new, avail;
    logic [MA_W+1:0]         m_start;

    always_comb
    begin
        macd_diff = ema_f_reg - ema_s_reg;
        if (macd_diff > S48_MAX)
            macd_new = S48_MAX[VAL_W-1:0];
        else if (macd_diff < S48_MIN)
            macd_new = S48_MIN[VAL_W-1:0];
        else
            macd_new = macd_diff[VAL_W-1:0];
        mhead_new  = (mhead_reg == MA_W'(MAX_SIGNAL - 1)) ? '0 : mhead_reg + MA_W'(1);
        mcount_new = (mcount_reg == MCOUNT_CAP) ? mcount_reg : mcount_reg + MC_W'(1);
        avail      = (mcount_new > MC_W'(MAX_SIGNAL)) ? MC_W'(MAX_SIGNAL) : mcount_new;
        m_start    = (MA_W + 2)'(mhead_new)
                   + (((MA_W + 2)'(mhead_new) < (MA_W + 2)'(sig_e_reg))
                      ? (MA_W + 2)'(MAX_SIGNAL) : '0)
                   - (MA_W + 2)'(sig_e_reg);
    end

    // crossover decision
    logic   rdy_now, can_trade;
    trade_t trade_c;

    always_comb
    begin
        rdy_now   = ready_flag_reg || ready_hit_reg;
        can_trade = rdy_now && !err_reg && (mcount_reg >= MC_W'(2)) && (scount_reg >= 2'd2);
        trade_c   = TRADE_NONE;
        if (can_trade)
        begin
            if (prior_reg <= pair0_reg && cur_reg > pair1_reg)
                trade_c = TRADE_BUY;
            else if (prior_reg >= pair0_reg && cur_reg < pair1_reg)
                trade_c = TRADE_SELL;
        end
    end

    logic out_free;
    assign out_free = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_SETUP;
            ST_SETUP:  state_next = win_go ? ST_P_RD : ST_FIN;
            ST_P_RD:   state_next = ST_P_X;
            ST_P_X:
            begin
                if (!first_reg)
                    state_next = ST_P_WF;
                else if (left_reg == '0)
                    state_next = ST_M_CALC;
                else
                    state_next = ST_P_RD;
            end
            ST_P_WF:   if (ema_done) state_next = ST_P_WS;
            ST_P_WS:
            begin
                if (ema_done)
                    state_next = (left_reg == '0) ? ST_M_CALC : ST_P_RD;
            end
            ST_M_CALC: state_next = (avail >= MC_W'(sig_e_reg)) ? ST_G_RD : ST_FIN;
            ST_G_RD:   state_next = ST_G_X;
            ST_G_X:
            begin
                if (!first_reg)
                    state_next = ST_G_W;
                else if (left_reg == '0)
                    state_next = ST_G_END;
                else
                    state_next = ST_G_RD;
            end
            ST_G_W:
            begin
                if (ema_done)
                    state_next = (left_reg == '0) ? ST_G_END : ST_G_RD;
            end
            ST_G_END:  state_next = ST_FIN;
            ST_FIN:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fast_len_reg   <= 6'd12;
            slow_len_reg   <= 7'd26;
            signal_len_reg <= 6'd9;
            head_reg       <= '0;
            count_reg      <= '0;
            mhead_reg      <= '0;
            mcount_reg     <= '0;
            scount_reg     <= '0;
            ready_flag_reg <= 1'b0;
            prior_reg      <= '0;
            cur_reg        <= '0;
            pair0_reg      <= '0;
            pair1_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_FAST:   fast_len_reg   <= cfg_data[5:0];
                    CFG_SLOW:   slow_len_reg   <= cfg_data;
                    CFG_SIGNAL: signal_len_reg <= cfg_data[5:0];
                    default:    ;
                endcase
            end

            if (p_we)
            begin
                head_reg  <= (head_reg == PA_W'(PRICE_DEPTH - 1)) ? '0 : head_reg + PA_W'(1);
                count_reg <= (count_reg == CNT_W'(PRICE_DEPTH)) ? count_reg
                                                                 : count_reg + CNT_W'(1);
            end

            if (state_reg == ST_M_CALC)
            begin
                if (mcount_reg != '0)
                    prior_reg <= cur_reg;
                cur_reg    <= macd_new;
                mhead_reg  <= mhead_new;
                mcount_reg <= mcount_new;
            end

            if (state_reg == ST_G_END)
            begin
                pair0_reg <= pair1_reg;
                pair1_reg <= ema_g_reg[VAL_W-1:0];
                if (scount_reg != 2'd2)
                    scount_reg <= scount_reg + 2'd1;
            end

            if (state_reg == ST_FIN && out_free)
            begin
                ready_flag_reg <= rdy_now;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            alpha_f_reg <= alpha_tab[TIDX_W'(fast_e)];
            alpha_s_reg <= alpha_tab[TIDX_W'(slow_c)];
            alpha_g_reg <= alpha_tab[TIDX_W'(sig_c)];
            slow_e_reg  <= slow_c;
            sig_e_reg   <= sig_c;
            err_reg     <= err_c;
        end

        unique case (state_reg)
            ST_SETUP:
            begin
                idx_reg       <= p_start[PA_W-1:0];
                left_reg      <= win;
                first_reg     <= 1'b1;
                ready_hit_reg <= win_ready;
            end
            ST_P_RD:
            begin
                idx_reg  <= (idx_reg == PA_W'(PRICE_DEPTH - 1)) ? '0 : idx_reg + PA_W'(1);
                left_reg <= left_reg - CNT_W'(1);
            end
            ST_P_X:
            begin
                x_reg <= x_price;
                if (first_reg)
                begin
                    ema_f_reg <= x_price;
                    ema_s_reg <= x_price;
                    first_reg <= 1'b0;
                end
            end
            ST_P_WF:
            begin
                if (ema_done)
                    ema_f_reg <= ema_res;
            end
            ST_P_WS:
            begin
                if (ema_done)
                    ema_s_reg <= ema_res;
            end
            ST_M_CALC:
            begin
                midx_reg  <= m_start[MA_W-1:0];
                left_reg  <= CNT_W'(sig_e_reg);
                first_reg <= 1'b1;
            end
            ST_G_RD:
            begin
                midx_reg <= (midx_reg == MA_W'(MAX_SIGNAL - 1)) ? '0 : midx_reg + MA_W'(1);
                left_reg <= left_reg - CNT_W'(1);
            end
            ST_G_X:
            begin
                if (first_reg)
                begin
                    ema_g_reg <= x_macd;
                    first_reg <= 1'b0;
                end
            end
            ST_G_W:
            begin
                if (ema_done)
                    ema_g_reg <= ema_res;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    trade_reg     <= trade_c;
                    macd_out_reg  <= cur_reg;
                    sig_out_reg   <= pair1_reg;
                    ready_out_reg <= rdy_now;
                    err_out_reg   <= err_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign trade_signal = trade_reg;
    assign macd_value   = macd_out_reg;
    assign signal_value = sig_out_reg;
    assign ready_res    = ready_out_reg;
    assign config_error = err_out_reg;

endmodule

// ----- rtl/mcs_checker.sv -----
// ----------------------------------------------------------------------------
// mcs_checker
// port level checks of the macd crossover signal block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcs_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                cfg_we,
    input logic [mcs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input logic [mcs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [mcs_pkg::PRICE_W-1:0]         close_price,
    input logic                                out_valid,
    input logic                                out_ready,
    input mcs_pkg::trade_t                     trade_signal,
    input logic signed [mcs_pkg::VAL_W-1:0]    macd_value,
    input logic signed [mcs_pkg::VAL_W-1:0]    signal_value,
    input logic                                ready_res,
    input logic                                config_error
);
    import mcs_pkg::*;

    // a configuration error always silences the trade
    `ASSERT_SAME(a_err_quiet, clk, rst_n, out_valid && config_error, trade_signal == TRADE_NONE, "trade with config error")
    // no trade before the block is warmed up
    `ASSERT_SAME(a_warm_quiet, clk, rst_n, out_valid && !ready_res, trade_signal == TRADE_NONE, "trade before ready")
    // the sequencer is busy the cycle after taking an item
    `ASSERT_NEXT(a_busy, clk, rst_n, in_valid && in_ready, !in_ready, "took two items back to back")
    // a stalled result holds
    `ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(macd_value) && $stable(trade_signal), "stalled item changed")

endmodule

bind macd_crossover_signal mcs_checker u_mcs_checker (.*);
